>>> design/ppts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppts_pkg;

  // Request operation codes
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  slot;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  priority_req;
  } in_req_t;

  typedef struct packed {
    logic        ran_valid;
    logic [3:0]  ran_slot;
    logic        finished;
    logic [15:0] completion_time;
    logic [15:0] turnaround;
    logic [15:0] waiting;
    logic        all_done;
    logic [15:0] time_now;
  } out_res_t;

endpackage

`default_nettype wire

>>> design/preemptive_priority_tick_scheduler_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: a load request gives its result in the cycle after acceptance; a tick request
//   scans the active slots through the single read port of the task table and one shared
//   priority comparator, then runs the picked slot in ST_RUN_RD and ST_RUN_WB (and ST_FIN on
//   a finish); a restart sweeps all MAX_TASKS slots to restore every loaded remaining burst.
// Throughput: one request at a time; the next is taken once the result has been delivered.
// Reset: time goes to zero, every slot is marked finished and unloaded, task_count is 16;
//   table contents are undefined until loaded.
module preemptive_priority_tick_scheduler_unit #(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [4:0]            cfg_data_i,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  ppts_pkg::in_req_t    in_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output ppts_pkg::out_res_t   out_o
);

  // Index width into the table, and a count width that can hold MAX_TASKS itself
  localparam int SW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  // Width used to compare and subtract times against 16-bit arrival values
  localparam int TW = (TIME_BITS > 16) ? TIME_BITS : 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RUN_RD,
    ST_RUN_WB,
    ST_FIN,
    ST_OUT
  } state_e;

  // One table word per slot: read-modify-write keeps a single write port
  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [7:0]  prio;
  } word_t;

  state_e                 state_q, state_d;
  logic [TIME_BITS-1:0]   time_q, time_d;
  logic [4:0]             tc_q, tc_d;
  logic [MAX_TASKS-1:0]   fin_q, fin_d;
  logic [MAX_TASKS-1:0]   loaded_q, loaded_d;
  logic [CW-1:0]          scan_q, scan_d;
  logic                   cmp_vld_q, cmp_vld_d;
  logic [SW-1:0]          cmp_idx_q, cmp_idx_d;
  logic                   restart_q, restart_d;
  logic                   found_q, found_d;
  logic [SW-1:0]          pick_q, pick_d;
  logic [7:0]             best_q, best_d;
  logic [TW-1:0]          tat_q, tat_d;
  logic [15:0]            burst_q, burst_d;
  ppts_pkg::out_res_t     res_q, res_d;

  // Task table
  word_t                  mem_q [MAX_TASKS];
  word_t                  rd_word_q;
  logic [SW-1:0]          rd_addr;
  logic                   mem_we;
  logic [SW-1:0]          mem_waddr;
  word_t                  mem_wdata;

  logic [CW-1:0]          active_n;
  logic [CW-1:0]          scan_limit;
  logic                   issue;
  logic                   eligible;
  logic                   all_done;
  logic [15:0]            rem_new;
  logic [TW-1:0]          wait_val;

  // Clamp task_count to the table depth
  always_comb begin
    if (32'(tc_q) > 32'(MAX_TASKS)) begin
      active_n = CW'(MAX_TASKS);
    end else begin
      active_n = CW'(tc_q);
    end
  end

  // No active slot left pending
  always_comb begin
    all_done = 1'b1;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if ((32'(i) < 32'(active_n)) && !fin_q[i]) begin
        all_done = 1'b0;
      end
    end
  end

  // A restart sweeps the whole table, a tick only the active slots
  assign scan_limit = restart_q ? CW'(MAX_TASKS) : active_n;
  assign issue      = (scan_q < scan_limit);

  // Slot under comparison: unfinished and already arrived
  assign eligible = !fin_q[cmp_idx_q] && (TW'(rd_word_q.arrival) <= TW'(time_q));

  assign rem_new  = (rd_word_q.remaining != 16'd0) ? (rd_word_q.remaining - 16'd1)
                                                  : rd_word_q.remaining;
  // Clamp waiting at zero when time saturation shortened the turnaround
  assign wait_val = (tat_q > TW'(burst_q)) ? (tat_q - TW'(burst_q)) : '0;

  always_comb begin
    state_d   = state_q;
    time_d    = time_q;
    tc_d      = tc_q;
    fin_d     = fin_q;
    loaded_d  = loaded_q;
    scan_d    = scan_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    restart_d = restart_q;
    found_d   = found_q;
    pick_d    = pick_q;
    best_d    = best_q;
    tat_d     = tat_q;
    burst_d   = burst_q;
    res_d     = res_q;
    rd_addr   = SW'(scan_q);
    mem_we    = 1'b0;
    mem_waddr = cmp_idx_q;
    mem_wdata = rd_word_q;

    // Take a configuration write at any edge where it is enabled
    if (cfg_we_i) begin
      tc_d = cfg_data_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_d     = '0;
          scan_d    = '0;
          found_d   = 1'b0;
          best_d    = '0;
          pick_d    = '0;
          restart_d = 1'b0;
          case (in_i.op)
            ppts_pkg::OP_LOAD: begin
              // Drop loads to slots beyond the table
              if (32'(in_i.slot) < 32'(MAX_TASKS)) begin
                mem_we              = 1'b1;
                mem_waddr           = SW'(in_i.slot);
                mem_wdata.arrival   = in_i.arrival;
                mem_wdata.burst     = in_i.burst;
                mem_wdata.remaining = in_i.burst;
                mem_wdata.prio      = in_i.priority_req;
                fin_d[SW'(in_i.slot)]    = (in_i.burst == 16'd0);
                loaded_d[SW'(in_i.slot)] = 1'b1;
              end
              state_d = ST_OUT;
            end
            ppts_pkg::OP_TICK: begin
              state_d = ST_SCAN;
            end
            ppts_pkg::OP_RESTART: begin
              time_d    = '0;
              restart_d = 1'b1;
              state_d   = ST_SCAN;
            end
            default: begin
              state_d = ST_OUT;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue stage: read the next slot
        if (issue) begin
          scan_d    = scan_q + CW'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = SW'(scan_q);
        end
        // Compare stage: work on the word read last cycle
        if (cmp_vld_q) begin
          if (restart_q) begin
            if (loaded_q[cmp_idx_q]) begin
              mem_we              = 1'b1;
              mem_waddr           = cmp_idx_q;
              mem_wdata.remaining = rd_word_q.burst;
              fin_d[cmp_idx_q]    = (rd_word_q.burst == 16'd0);
            end
          end else if (eligible && (!found_q || (rd_word_q.prio > best_q))) begin
            found_d = 1'b1;
            pick_d  = cmp_idx_q;
            best_d  = rd_word_q.prio;
          end
        end
        if (!issue && !cmp_vld_q) begin
          if (restart_q) begin
            state_d = ST_OUT;
          end else begin
            // Advance time, saturating at its maximum
            if (time_q != {TIME_BITS{1'b1}}) begin
              time_d = time_q + TIME_BITS'(1);
            end
            state_d = found_q ? ST_RUN_RD : ST_OUT;
          end
        end
      end

      ST_RUN_RD: begin
        rd_addr = pick_q;
        state_d = ST_RUN_WB;
      end

      ST_RUN_WB: begin
        mem_we              = 1'b1;
        mem_waddr           = pick_q;
        mem_wdata.remaining = rem_new;
        res_d.ran_valid     = 1'b1;
        res_d.ran_slot      = 4'(pick_q);
        if (rem_new == 16'd0) begin
          fin_d[pick_q]         = 1'b1;
          res_d.finished        = 1'b1;
          res_d.completion_time = 16'(time_q);
          tat_d   = TW'(time_q) - TW'(rd_word_q.arrival);
          burst_d = rd_word_q.burst;
          state_d = ST_FIN;
        end else begin
          state_d = ST_OUT;
        end
      end

      ST_FIN: begin
        res_d.turnaround = 16'(tat_q);
        res_d.waiting    = 16'(wait_val);
        state_d          = ST_OUT;
      end

      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      time_q    <= '0;
      tc_q      <= 5'd16;
      fin_q     <= '1;
      loaded_q  <= '0;
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
      restart_q <= 1'b0;
      found_q   <= 1'b0;
      pick_q    <= '0;
      best_q    <= '0;
      tat_q     <= '0;
      burst_q   <= '0;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      time_q    <= time_d;
      tc_q      <= tc_d;
      fin_q     <= fin_d;
      loaded_q  <= loaded_d;
      scan_q    <= scan_d;
      cmp_vld_q <= cmp_vld_d;
      cmp_idx_q <= cmp_idx_d;
      restart_q <= restart_d;
      found_q   <= found_d;
      pick_q    <= pick_d;
      best_q    <= best_d;
      tat_q     <= tat_d;
      burst_q   <= burst_d;
      res_q     <= res_d;
    end
  end

  // Table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_word_q <= mem_q[rd_addr];
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  always_comb begin
    out_o          = res_q;
    out_o.all_done = all_done;
    out_o.time_now = 16'(time_q);
  end

  // Never take a request while a result is still offered
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("request taken while result pending");

  // A finish is only reported for a tick that ran a slot
  a_fin_ran: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.finished |-> out_o.ran_valid)
    else $error("finish reported without a running slot");

  // Completion time is the time after the tick
  a_fin_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.finished |-> (out_o.completion_time == out_o.time_now))
    else $error("completion time differs from current time");

  // A tick scan compares only active slots
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && cmp_vld_q && !restart_q |-> (CW'(cmp_idx_q) < active_n))
    else $error("scan compared an inactive slot");

  // A picked slot ran in the next result
  a_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN_WB) |=> res_q.ran_valid)
    else $error("picked slot not reported");

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the preemptive priority tick scheduler.
//
// Each request is predicted at the moment it is accepted. The prediction is a
// copy of the task table held here: slot contents, remaining bursts, finished
// and loaded flags, the current time and the number of active slots. Each
// predicted result joins a queue. Every result the block delivers is popped
// and compared field by field.
//
// Test tasks run in turn:
//   - an empty table right after reset: idle tick, restart, unused opcode
//   - priority order: ties go to the lower slot, a late high-priority
//     arrival preempts, a zero burst never runs, a task that never arrives
//     stays pending, restart replays the schedule
//   - task_count limits: zero slots, a value above the table size, one slot
//   - random schedules: loads, then ticks until the table drains, with
//     preempting loads, restarts and unused opcodes mixed in
//   - back-to-back run: one long task with idle ticks before it arrives,
//     ticked until it finishes
//
// The request side idles at random and the result side stalls at random,
// except in the back-to-back run, which runs with no gaps at all.
module tb_top;

  localparam int SLOTS = 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [15:0] TIME_MAX = 16'hFFFF;
  localparam int RANDOM_REQUESTS = 1050;
  // A tick scans every active slot, so allow the longest scan plus margin.
  localparam int SETTLE_CYCLES = 40;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [4:0]          cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  ppts_pkg::in_req_t   in_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  ppts_pkg::out_res_t  out_o;

  preemptive_priority_tick_scheduler_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  // Copy of the task table and schedule clock that the predictions use.
  logic [15:0] sched_arrival [SLOTS];
  logic [15:0] sched_burst   [SLOTS];
  logic [15:0] sched_left    [SLOTS];
  logic [7:0]  sched_prio    [SLOTS];
  bit          sched_done    [SLOTS];
  bit          sched_loaded  [SLOTS];
  logic [15:0] sched_time;
  int          live_slots;

  ppts_pkg::out_res_t pending_results [$];

  int send_gap_pct = 17;
  int sink_stall_pct = 17;
  int requests_sent = 0;
  int results_checked = 0;
  int tasks_completed = 0;
  int failures = 0;
  logic [15:0] time_peak = '0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs; well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("preemptive_priority_tick_scheduler_unit regression: fail");
    $finish;
  end

  // Stall the result side at random; the stall rate is zero during the
  // back-to-back run.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic bit all_slots_done();
    for (int i = 0; i < live_slots; i++)
      if (!sched_done[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Apply one request to the table copy and return the result it yields.
  function automatic ppts_pkg::out_res_t schedule_step(ppts_pkg::in_req_t req);
    ppts_pkg::out_res_t res;
    bit                 found;
    int                 pick;
    logic [15:0]        tat;
    res = '0;
    found = 1'b0;
    pick = 0;
    case (req.op)
      ppts_pkg::OP_LOAD: begin
        sched_arrival[req.slot] = req.arrival;
        sched_burst[req.slot]   = req.burst;
        sched_left[req.slot]    = req.burst;
        sched_prio[req.slot]    = req.priority_req;
        sched_done[req.slot]    = (req.burst == 16'd0);
        sched_loaded[req.slot]  = 1'b1;
      end
      ppts_pkg::OP_RESTART: begin
        // Slots never loaded stay finished.
        sched_time = '0;
        for (int i = 0; i < SLOTS; i++) begin
          if (sched_loaded[i]) begin
            sched_left[i] = sched_burst[i];
            sched_done[i] = (sched_burst[i] == 16'd0);
          end
        end
      end
      ppts_pkg::OP_TICK: begin
        // Highest priority among arrived, unfinished slots; strict compare
        // keeps the lower slot on a tie.
        for (int i = 0; i < live_slots; i++) begin
          if (!sched_done[i] && sched_arrival[i] <= sched_time &&
              (!found || sched_prio[i] > sched_prio[pick])) begin
            found = 1'b1;
            pick = i;
          end
        end
        if (sched_time != TIME_MAX) sched_time = sched_time + 16'd1;
        if (found) begin
          res.ran_valid = 1'b1;
          res.ran_slot = 4'(pick);
          if (sched_left[pick] != 16'd0) sched_left[pick] = sched_left[pick] - 16'd1;
          if (sched_left[pick] == 16'd0) begin
            tat = sched_time - sched_arrival[pick];
            sched_done[pick] = 1'b1;
            res.finished = 1'b1;
            res.completion_time = sched_time;
            res.turnaround = tat;
            // A saturated clock can make turnaround shorter than the burst.
            res.waiting = (tat > sched_burst[pick]) ? tat - sched_burst[pick] : 16'd0;
          end
        end
      end
      default: ;
    endcase
    res.all_done = all_slots_done();
    res.time_now = sched_time;
    return res;
  endfunction

  function automatic ppts_pkg::in_req_t random_request(logic [1:0] op);
    ppts_pkg::in_req_t req;
    req.op = op;
    req.slot = 4'($urandom);
    req.arrival = 16'($urandom);
    req.burst = 16'($urandom);
    req.priority_req = 8'($urandom);
    return req;
  endfunction

  function automatic ppts_pkg::in_req_t load_request(logic [3:0] slot, logic [15:0] arrival,
                                                     logic [15:0] burst, logic [7:0] prio);
    ppts_pkg::in_req_t req;
    req.op = ppts_pkg::OP_LOAD;
    req.slot = slot;
    req.arrival = arrival;
    req.burst = burst;
    req.priority_req = prio;
    return req;
  endfunction

  // Offer one request, idling first at random. Valid is left high on return
  // so that a following request can go out at the next edge without a gap.
  // Ready is sampled at the falling edge, where it is stable; the handshake
  // then completes at the next rising edge.
  task automatic send_request(ppts_pkg::in_req_t req);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= req;
    do @(negedge clk_i); while (!in_ready_o);
    pending_results.push_back(schedule_step(req));
    @(posedge clk_i);
    // Unused opcodes change no task state in the block; keep them out of the count.
    if (req.op != OP_UNUSED) requests_sent++;
  endtask

  // Drop valid and hold until every predicted result has been delivered.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Write task_count only once the block is idle.
  task automatic set_task_count(logic [4:0] value);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    live_slots = (value > SLOTS) ? SLOTS : int'(value);
  endtask

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  // Result checker: a result is taken at the rising edge that follows a
  // falling edge where valid and ready are both high.
  always @(negedge clk_i) begin
    ppts_pkg::out_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: %p", out_o);
        failures++;
      end else begin
        want = pending_results.pop_front();
        compare_field("ran_valid", 16'(want.ran_valid), 16'(out_o.ran_valid));
        compare_field("ran_slot", 16'(want.ran_slot), 16'(out_o.ran_slot));
        compare_field("finished", 16'(want.finished), 16'(out_o.finished));
        compare_field("completion_time", want.completion_time, out_o.completion_time);
        compare_field("turnaround", want.turnaround, out_o.turnaround);
        compare_field("waiting", want.waiting, out_o.waiting);
        compare_field("all_done", 16'(want.all_done), 16'(out_o.all_done));
        compare_field("time_now", want.time_now, out_o.time_now);
        results_checked++;
        if (want.finished) tasks_completed++;
        if (want.time_now > time_peak) time_peak = want.time_now;
      end
    end
  end

  // Nothing loaded: every slot counts as finished, so ticks are idle.
  task automatic test_empty_table();
    send_request(random_request(ppts_pkg::OP_TICK));
    send_request(random_request(ppts_pkg::OP_RESTART));
    send_request(random_request(OP_UNUSED));
  endtask

  task automatic test_priority_order();
    send_request(load_request(4'd0, 16'd0, 16'd3, 8'd1));
    // Same priority as slot 0; the lower slot must win the tie.
    send_request(load_request(4'd2, 16'd0, 16'd2, 8'd1));
    // Arrives at time 2 with a high priority and preempts slot 0.
    send_request(load_request(4'd5, 16'd2, 16'd1, 8'd200));
    // Zero burst: finished on load, never runs.
    send_request(load_request(4'd3, 16'd0, 16'd0, 8'd255));
    send_request(load_request(4'd1, 16'd1, 16'd1, 8'd0));
    // Never arrives within the run, so all_done stays low.
    send_request(load_request(4'd15, TIME_MAX, 16'hFFFF, 8'hFF));
    repeat (8) send_request(random_request(ppts_pkg::OP_TICK));
    // Replay the schedule from time zero.
    send_request(random_request(ppts_pkg::OP_RESTART));
    repeat (3) send_request(random_request(ppts_pkg::OP_TICK));
    send_request(load_request(4'd0, 16'd0, 16'd0, 8'd0) | {OP_UNUSED, 44'h0});
  endtask

  task automatic test_task_count_limits();
    // No active slot: idle tick with all_done high.
    set_task_count(5'd0);
    send_request(random_request(ppts_pkg::OP_TICK));
    // Above the table size: saturates to all slots.
    set_task_count(5'd31);
    send_request(random_request(ppts_pkg::OP_TICK));
    set_task_count(5'd1);
    send_request(random_request(ppts_pkg::OP_TICK));
  endtask

  // Well-formed schedules with random content: load a few slots, then tick
  // until the table drains, with noise mixed in.
  task automatic test_random_schedules();
    int                stop_at;
    int                n_load;
    int                tick_cap;
    ppts_pkg::in_req_t req;
    stop_at = requests_sent + RANDOM_REQUESTS;
    while (requests_sent < stop_at) begin
      case ($urandom_range(9))
        0:       set_task_count(5'($urandom_range(31)));
        1, 2, 3: set_task_count(5'(SLOTS));
        default: set_task_count(5'($urandom_range(SLOTS, 1)));
      endcase
      if ($urandom_range(1)) send_request(random_request(ppts_pkg::OP_RESTART));
      n_load = $urandom_range(6, 1);
      for (int k = 0; k < n_load; k++) begin
        req = random_request(ppts_pkg::OP_LOAD);
        if ($urandom_range(7) != 0) begin
          // Mostly active slots, near arrivals, short bursts; narrow the
          // priority range now and then to force ties.
          if (live_slots > 0) req.slot = 4'($urandom_range(live_slots - 1));
          req.arrival = 16'($urandom_range(20));
          req.burst = 16'($urandom_range(6));
          if ($urandom_range(1)) req.priority_req = 8'($urandom_range(3));
        end
        send_request(req);
      end
      tick_cap = $urandom_range(60, 10);
      for (int t = 0; t < tick_cap && !all_slots_done(); t++) begin
        case ($urandom_range(19))
          0: send_request(random_request(ppts_pkg::OP_LOAD));
          1: begin
            // Late arrival, likely to preempt the running slot.
            req = random_request(ppts_pkg::OP_LOAD);
            if (live_slots > 0) req.slot = 4'($urandom_range(live_slots - 1));
            req.arrival = sched_time + 16'($urandom_range(3));
            req.burst = 16'($urandom_range(6, 1));
            send_request(req);
          end
          2: send_request(random_request(ppts_pkg::OP_RESTART));
          3: send_request(random_request(OP_UNUSED));
          default: send_request(random_request(ppts_pkg::OP_TICK));
        endcase
      end
      // Up to two extra ticks after the tick loop; idle ones if the table has drained.
      repeat ($urandom_range(2)) send_request(random_request(ppts_pkg::OP_TICK));
    end
  endtask

  // One long task arriving at 5: idle ticks first, then it runs to the end.
  // This is the stretch with no idling on either side.
  task automatic test_no_idle_run();
    set_task_count(5'd1);
    send_gap_pct = 0;
    sink_stall_pct = 0;
    send_request(load_request(4'd0, 16'd5, 16'd40, 8'd9));
    send_request(random_request(ppts_pkg::OP_RESTART));
    while (!all_slots_done()) send_request(random_request(ppts_pkg::OP_TICK));
    repeat (3) send_request(random_request(ppts_pkg::OP_TICK));
    send_request(random_request(ppts_pkg::OP_RESTART));
    send_gap_pct = 17;
    sink_stall_pct = 17;
  endtask

  initial begin
    sched_time = '0;
    live_slots = SLOTS;
    for (int i = 0; i < SLOTS; i++) begin
      sched_arrival[i] = '0;
      sched_burst[i] = '0;
      sched_left[i] = '0;
      sched_prio[i] = '0;
      sched_done[i] = 1'b1;
      sched_loaded[i] = 1'b0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_priority_order();
    test_task_count_limits();
    test_random_schedules();
    test_no_idle_run();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never delivered", pending_results.size());
      failures++;
    end
    $display("Covered %0d requests and %0d results, %0d task completions;",
             requests_sent, results_checked, tasks_completed);
    $display("schedule clock reached %0d, task_count swept from 0 to 31.", time_peak);
    if (failures == 0) begin
      $display("preemptive_priority_tick_scheduler_unit regression: pass");
    end else begin
      $display("preemptive_priority_tick_scheduler_unit regression: fail");
    end
    $finish;
  end

endmodule
